// File: rtl/core/swfflp_pkg.sv
`default_nettype none
package swfflp_pkg;

	// Parse phases of the filter list walker
	typedef enum logic [4:0] {
		PH_COUNT  = 5'd0,
		PH_TYPE   = 5'd1,
		PH_C0     = 5'd2,
		PH_C1     = 5'd3,
		PH_BX     = 5'd4,
		PH_BY     = 5'd5,
		PH_ANG    = 5'd6,
		PH_DIST   = 5'd7,
		PH_STR    = 5'd8,
		PH_FLAGS  = 5'd9,
		PH_GCOUNT = 5'd10,
		PH_COLS   = 5'd11,
		PH_ROWS   = 5'd12,
		PH_SKIP   = 5'd13
	} phase_t;

	// Record type codes
	localparam logic [2:0] KIND_SHADOW   = 3'd0;
	localparam logic [2:0] KIND_BLUR     = 3'd1;
	localparam logic [2:0] KIND_GLOW     = 3'd2;
	localparam logic [2:0] KIND_BEVEL    = 3'd3;
	localparam logic [2:0] KIND_GGLOW    = 3'd4;
	localparam logic [2:0] KIND_CONVOLVE = 3'd5;
	localparam logic [2:0] KIND_CMATRIX  = 3'd6;
	localparam logic [2:0] KIND_GBEVEL   = 3'd7;

	// Result kind codes beyond the stream types
	localparam logic [3:0] KIND_EMPTY   = 4'd8;
	localparam logic [3:0] KIND_UNKNOWN = 4'd15;

	// Highest valid type byte
	localparam logic [7:0] TYPE_MAX = 8'd7;

	// Body lengths of the skipped kinds
	localparam logic [17:0] CMATRIX_LEN  = 18'd80;
	localparam logic [17:0] GRAD_BASE    = 18'd19;
	localparam logic [17:0] CONV_BASE    = 18'd13;

	// Configuration register indexes
	localparam logic [0:0] REG_STORE_EN = 1'b0;

	// One result item
	typedef struct packed {
		logic [3:0]  filter_kind;
		logic [31:0] first_colour;
		logic [31:0] second_colour;
		logic [36:0] blur_x_twips;
		logic [36:0] blur_y_twips;
		logic [31:0] angle_raw;
		logic [31:0] distance_raw;
		logic [15:0] strength_raw;
		logic [4:0]  pass_count;
		logic [3:0]  mode_bits;
		logic [7:0]  added_count;
		logic        list_end;
	} res_t;

	// Scale a 16.16 blur word into twips (times 20)
	function automatic logic [36:0] to_twips(input logic [31:0] v);
		to_twips = {1'b0, v, 4'b0000} + {3'b000, v, 2'b00};
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/swf_filter_list_parser_unit.sv
`default_nettype none
// Filter list parser: takes one stream byte per cycle while in_stall is low and
// emits one result item per record (or one for an empty list) on the record's last
// byte. Bytes pass an input register; the parser steps while the skid entry is free
// and registers each result item into the output register or the one-item skid
// entry behind it, so input keeps flowing while a result waits; in_stall rises only
// once both hold a result. The user must write store_enabled (address 0) only while
// the stream is idle; the block itself does not enforce this.
module swf_filter_list_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  stream_byte,
	// Result stream
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       filter_kind,
	output logic [31:0]      first_colour,
	output logic [31:0]      second_colour,
	output logic [36:0]      blur_x_twips,
	output logic [36:0]      blur_y_twips,
	output logic [31:0]      angle_raw,
	output logic [31:0]      distance_raw,
	output logic [15:0]      strength_raw,
	output logic [4:0]       pass_count,
	output logic [3:0]       mode_bits,
	output logic [7:0]       added_count,
	output logic             list_end,
	// Configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import swfflp_pkg::*;

	logic       byte_valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       skid_full;
	logic       store_en;
	logic       res_valid;
	res_t       res;
	res_t       out_res;

	// Input register
	assign step     = byte_valid_s1 & ~skid_full;
	assign in_stall = byte_valid_s1 & skid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			byte_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) byte_s1 <= stream_byte;
	end

	swfflp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.store_en (store_en)
	);

	swfflp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.store_en  (store_en),
		.res_valid (res_valid),
		.res       (res)
	);

	swfflp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.skid_full (skid_full)
	);

	assign filter_kind   = out_res.filter_kind;
	assign first_colour  = out_res.first_colour;
	assign second_colour = out_res.second_colour;
	assign blur_x_twips  = out_res.blur_x_twips;
	assign blur_y_twips  = out_res.blur_y_twips;
	assign angle_raw     = out_res.angle_raw;
	assign distance_raw  = out_res.distance_raw;
	assign strength_raw  = out_res.strength_raw;
	assign pass_count    = out_res.pass_count;
	assign mode_bits     = out_res.mode_bits;
	assign added_count   = out_res.added_count;
	assign list_end      = out_res.list_end;

	// The skid entry only fills behind a held output item
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full |-> out_valid)
		else $error("skid entry full with output register empty");

	// No result is produced while the skid entry is occupied
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && skid_full))
		else $error("result produced with no room to hold it");

	// An empty-list item carries a zero count and closes the list
	a_empty_list: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && filter_kind == KIND_EMPTY) |-> (list_end && added_count == 8'd0))
		else $error("empty-list item with bad count or end mark");

	// A held result stays while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_res)))
		else $error("stalled result item changed");
endmodule
`default_nettype wire

// File: rtl/core/swfflp_cfg.sv
`default_nettype none
module swfflp_cfg (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output logic             store_en
);
	import swfflp_pkg::*;

	logic store_en_q;
	logic wr_en;

	// Decode a completed write to the store enable register
	assign wr_en = psel & penable & pwrite & (paddr[2] == REG_STORE_EN);

	// Hold the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_en_q <= 1'b1;
		end else if (wr_en) begin
			store_en_q <= pwdata[0];
		end
	end

	// Read back
	always_comb begin
		unique case (paddr[2])
			REG_STORE_EN: prdata = {31'b0, store_en_q};
			default:      prdata = 32'b0;
		endcase
	end

	assign pready   = 1'b1;
	assign store_en = store_en_q;
endmodule
`default_nettype wire

// File: rtl/core/swfflp_parse.sv
`default_nettype none
module swfflp_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        byte_s1,
	input  wire logic              store_en,
	output logic                   res_valid,
	output swfflp_pkg::res_t       res
);
	import swfflp_pkg::*;

	phase_t phase_q, phase_d;

	logic [7:0]  records_q, records_d;
	logic [7:0]  added_q, added_d;
	logic [2:0]  pos_q, pos_d;
	logic [31:0] word_q, word_d;
	logic [17:0] skip_q, skip_d;
	logic [2:0]  kind_q, kind_d;
	logic [7:0]  cols_q, cols_d;
	logic [31:0] c0_q, c0_d, c1_q, c1_d;
	logic [31:0] bx_q, bx_d, by_q, by_d;
	logic [31:0] ang_q, ang_d, dist_q, dist_d;
	logic [15:0] str_q, str_d;

	// Shared decode of the current byte
	logic [7:0]  rl_dec;
	logic [17:0] skip_dec;
	logic [3:0]  pos_inc;
	logic        field_done;
	logic [31:0] word_new;
	logic [15:0] conv_prod;
	logic        rec_last;

	assign rl_dec    = records_q - 8'd1;
	assign skip_dec  = (skip_q != 18'd0) ? (skip_q - 18'd1) : skip_q;
	assign pos_inc   = {1'b0, pos_q} + 4'd1;
	assign field_done = (phase_q == PH_STR) ? (pos_inc >= 4'd2) : (pos_inc >= 4'd4);
	assign word_new  = ((phase_q == PH_C0) || (phase_q == PH_C1)) ?
		{word_q[23:0], byte_s1} :
		(word_q | ({24'b0, byte_s1} << {pos_q[1:0], 3'b000}));
	assign conv_prod = cols_q * byte_s1;
	assign rec_last  = (records_q == 8'd0);

	// Next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_COUNT: phase_d = (byte_s1 == 8'd0) ? PH_COUNT : PH_TYPE;
			PH_TYPE: begin
				if (byte_s1 > TYPE_MAX) begin
					phase_d = (rl_dec == 8'd0) ? PH_COUNT : PH_TYPE;
				end else begin
					case (byte_s1[2:0])
						KIND_BLUR:                          phase_d = PH_BX;
						KIND_SHADOW, KIND_GLOW, KIND_BEVEL: phase_d = PH_C0;
						KIND_CONVOLVE:                      phase_d = PH_COLS;
						KIND_CMATRIX:                       phase_d = PH_SKIP;
						default:                            phase_d = PH_GCOUNT;
					endcase
				end
			end
			PH_C0, PH_C1, PH_BX, PH_BY, PH_ANG, PH_DIST, PH_STR: begin
				if (field_done) begin
					case (phase_q)
						PH_C0:   phase_d = (kind_q == KIND_BEVEL) ? PH_C1 : PH_BX;
						PH_C1:   phase_d = PH_BX;
						PH_BX:   phase_d = PH_BY;
						PH_BY: begin
							if (kind_q == KIND_BLUR)      phase_d = PH_FLAGS;
							else if (kind_q == KIND_GLOW) phase_d = PH_STR;
							else                          phase_d = PH_ANG;
						end
						PH_ANG:  phase_d = PH_DIST;
						PH_DIST: phase_d = PH_STR;
						default: phase_d = PH_FLAGS;
					endcase
				end
			end
			PH_FLAGS:  phase_d = rec_last ? PH_COUNT : PH_TYPE;
			PH_GCOUNT: phase_d = PH_SKIP;
			PH_COLS:   phase_d = PH_ROWS;
			PH_ROWS:   phase_d = PH_SKIP;
			PH_SKIP: begin
				if (skip_dec == 18'd0) phase_d = rec_last ? PH_COUNT : PH_TYPE;
			end
			default:   phase_d = PH_COUNT;
		endcase
	end

	// Datapath and result
	always_comb begin
		records_d = records_q;
		added_d   = added_q;
		pos_d     = pos_q;
		word_d    = word_q;
		skip_d    = skip_q;
		kind_d    = kind_q;
		cols_d    = cols_q;
		c0_d      = c0_q;
		c1_d      = c1_q;
		bx_d      = bx_q;
		by_d      = by_q;
		ang_d     = ang_q;
		dist_d    = dist_q;
		str_d     = str_q;

		res_valid         = 1'b0;
		res.filter_kind   = {1'b0, kind_q};
		res.first_colour  = c0_q;
		res.second_colour = c1_q;
		res.blur_x_twips  = to_twips(bx_q);
		res.blur_y_twips  = to_twips(by_q);
		res.angle_raw     = ang_q;
		res.distance_raw  = dist_q;
		res.strength_raw  = str_q;
		res.pass_count    = 5'd0;
		res.mode_bits     = 4'd0;
		res.added_count   = added_q;
		res.list_end      = rec_last;

		unique case (phase_q)
			PH_COUNT: begin
				// Start a list: clear count and held fields
				added_d = 8'd0;
				c0_d = 32'd0; c1_d = 32'd0; bx_d = 32'd0; by_d = 32'd0;
				ang_d = 32'd0; dist_d = 32'd0; str_d = 16'd0;
				records_d = byte_s1;
				if (byte_s1 == 8'd0) begin
					res_valid         = 1'b1;
					res.filter_kind   = KIND_EMPTY;
					res.first_colour  = 32'd0;
					res.second_colour = 32'd0;
					res.blur_x_twips  = 37'd0;
					res.blur_y_twips  = 37'd0;
					res.angle_raw     = 32'd0;
					res.distance_raw  = 32'd0;
					res.strength_raw  = 16'd0;
					res.added_count   = 8'd0;
					res.list_end      = 1'b1;
				end
			end
			PH_TYPE: begin
				// Open a record
				records_d = rl_dec;
				c0_d = 32'd0; c1_d = 32'd0; bx_d = 32'd0; by_d = 32'd0;
				ang_d = 32'd0; dist_d = 32'd0; str_d = 16'd0;
				pos_d  = 3'd0;
				word_d = 32'd0;
				if (byte_s1 > TYPE_MAX) begin
					res_valid         = 1'b1;
					res.filter_kind   = KIND_UNKNOWN;
					res.first_colour  = 32'd0;
					res.second_colour = 32'd0;
					res.blur_x_twips  = 37'd0;
					res.blur_y_twips  = 37'd0;
					res.angle_raw     = 32'd0;
					res.distance_raw  = 32'd0;
					res.strength_raw  = 16'd0;
					res.list_end      = (rl_dec == 8'd0);
				end else begin
					kind_d = byte_s1[2:0];
					if (byte_s1[2:0] == KIND_CMATRIX) skip_d = CMATRIX_LEN;
				end
			end
			PH_C0, PH_C1, PH_BX, PH_BY, PH_ANG, PH_DIST, PH_STR: begin
				// Assemble a field, store it on its last byte
				if (!field_done) begin
					word_d = word_new;
					pos_d  = pos_inc[2:0];
				end else begin
					word_d = 32'd0;
					pos_d  = 3'd0;
					case (phase_q)
						PH_C0:   c0_d   = word_new;
						PH_C1:   c1_d   = word_new;
						PH_BX:   bx_d   = word_new;
						PH_BY:   by_d   = word_new;
						PH_ANG:  ang_d  = word_new;
						PH_DIST: dist_d = word_new;
						default: str_d  = word_new[15:0];
					endcase
				end
			end
			PH_FLAGS: begin
				// Decode passes and mode bits, close the record
				if (store_en) added_d = added_q + 8'd1;
				res_valid       = 1'b1;
				res.added_count = added_d;
				if (kind_q == KIND_BLUR) begin
					res.pass_count = byte_s1[7:3];
				end else begin
					res.mode_bits = {(kind_q == KIND_BEVEL) & byte_s1[4], ~byte_s1[5],
						byte_s1[6], byte_s1[7]};
					res.pass_count = (kind_q == KIND_BEVEL) ? {1'b0, byte_s1[3:0]} :
						byte_s1[4:0];
				end
			end
			PH_GCOUNT: skip_d = GRAD_BASE + {8'b0, byte_s1, 2'b00} + {10'b0, byte_s1};
			PH_COLS:   cols_d = byte_s1;
			PH_ROWS:   skip_d = CONV_BASE + {conv_prod, 2'b00};
			PH_SKIP: begin
				// Drop body bytes, close the record on the last one
				skip_d = skip_dec;
				if (skip_dec == 18'd0) begin
					if (kind_q == KIND_CMATRIX) added_d = added_q + 8'd1 + {7'b0, store_en};
					res_valid       = 1'b1;
					res.added_count = added_d;
				end
			end
			default: ;
		endcase

		if (!step) res_valid = 1'b0;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_COUNT;
			records_q <= 8'd0;
			added_q   <= 8'd0;
			pos_q     <= 3'd0;
			skip_q    <= 18'd0;
			kind_q    <= 3'd0;
			cols_q    <= 8'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			records_q <= records_d;
			added_q   <= added_d;
			pos_q     <= pos_d;
			skip_q    <= skip_d;
			kind_q    <= kind_d;
			cols_q    <= cols_d;
		end
	end

	// Assembly word and held fields
	always_ff @(posedge clk) begin
		if (step) begin
			word_q <= word_d;
			c0_q   <= c0_d;
			c1_q   <= c1_d;
			bx_q   <= bx_d;
			by_q   <= by_d;
			ang_q  <= ang_d;
			dist_q <= dist_d;
			str_q  <= str_d;
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/swfflp_out_buf.sv
`default_nettype none
module swfflp_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire swfflp_pkg::res_t  push_res,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output swfflp_pkg::res_t       out_res,
	output logic                   skid_full
);
	import swfflp_pkg::*;

	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;
	logic out_fire;

	assign out_fire = out_valid_q & ~out_stall;

	// Track occupancy of output and skid entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!out_valid_q || out_fire) out_valid_q  <= 1'b1;
			else                          skid_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// Advance the item payloads
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) out_q <= skid_q;
		end else if (push) begin
			if (!out_valid_q || out_fire) out_q  <= push_res;
			else                          skid_q <= push_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign skid_full = skid_valid_q;
endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
module tb;
	import swfflp_pkg::*;

	// One queued stream byte; rush bytes go out back to back
	typedef struct {
		logic [7:0] data;
		bit         rush;
	} feed_t;

	// Content fill modes and the "choose at random" marker for record arguments
	localparam int FILL_RAND = 0;
	localparam int FILL_ZERO = 1;
	localparam int FILL_ONES = 2;
	localparam int PICK      = -1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  stream_byte = 8'h00;
	logic        out_stall = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;

	logic        in_stall;
	logic        out_valid;
	logic [3:0]  filter_kind;
	logic [31:0] first_colour;
	logic [31:0] second_colour;
	logic [36:0] blur_x_twips;
	logic [36:0] blur_y_twips;
	logic [31:0] angle_raw;
	logic [31:0] distance_raw;
	logic [15:0] strength_raw;
	logic [4:0]  pass_count;
	logic [3:0]  mode_bits;
	logic [7:0]  added_count;
	logic        list_end;
	logic [31:0] prdata;
	logic        pready;

	swf_filter_list_parser_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stream_byte(stream_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filter_kind(filter_kind),
		.first_colour(first_colour),
		.second_colour(second_colour),
		.blur_x_twips(blur_x_twips),
		.blur_y_twips(blur_y_twips),
		.angle_raw(angle_raw),
		.distance_raw(distance_raw),
		.strength_raw(strength_raw),
		.pass_count(pass_count),
		.mode_bits(mode_bits),
		.added_count(added_count),
		.list_end(list_end),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Parser shadow state
	phase_t      ph = PH_COUNT;
	logic [7:0]  recs_left = '0;
	logic [7:0]  n_added = '0;
	logic [7:0]  cols = '0;
	logic [2:0]  bpos = '0;
	logic [2:0]  kind = '0;
	logic [31:0] word = '0;
	logic [17:0] skip_cnt = '0;
	logic [31:0] col0 = '0, col1 = '0, bx = '0, by = '0, ang = '0, dist_w = '0;
	logic [15:0] strength = '0;
	logic        store_en = 1'b1;

	res_t        records_due[$];
	feed_t       byte_q[$];
	logic        in_taken = 1'b0;
	int          fails = 0;
	int          lead_bytes = 0;
	int          recs_made = 0;
	longint      limit_cycles = 5000;
	longint      cycles = 0;

	task automatic clear_fields();
		col0 = '0;
		col1 = '0;
		bx = '0;
		by = '0;
		ang = '0;
		dist_w = '0;
		strength = '0;
	endtask

	task automatic emit_record(input logic [3:0] k, input logic [4:0] passes,
			input logic [3:0] mode, input logic last);
		res_t r;
		r.filter_kind   = k;
		r.first_colour  = col0;
		r.second_colour = col1;
		r.blur_x_twips  = {5'd0, bx} * 37'd20;
		r.blur_y_twips  = {5'd0, by} * 37'd20;
		r.angle_raw     = ang;
		r.distance_raw  = dist_w;
		r.strength_raw  = strength;
		r.pass_count    = passes;
		r.mode_bits     = mode;
		r.added_count   = n_added;
		r.list_end      = last;
		records_due.push_back(r);
	endtask

	// Close a record; go back to the count byte after the last one
	task automatic finish_record(input logic [3:0] k, input logic [4:0] passes,
			input logic [3:0] mode);
		logic last;
		last = (recs_left == 8'd0);
		ph = last ? PH_COUNT : PH_TYPE;
		emit_record(k, passes, mode, last);
	endtask

	// Advance the parser by one stream byte
	task automatic walk_byte(input logic [7:0] b);
		logic [4:0] passes;
		logic [3:0] mode;
		case (ph)
		PH_COUNT: begin
			n_added = '0;
			clear_fields();
			if (b == 8'd0) begin
				recs_left = '0;
				emit_record(KIND_EMPTY, 5'd0, 4'd0, 1'b1);
			end else begin
				recs_left = b;
				ph = PH_TYPE;
			end
		end
		PH_TYPE: begin
			recs_left = recs_left - 8'd1;
			clear_fields();
			bpos = '0;
			word = '0;
			if (b > TYPE_MAX) begin
				finish_record(KIND_UNKNOWN, 5'd0, 4'd0);
			end else begin
				kind = b[2:0];
				case (kind)
				KIND_BLUR: ph = PH_BX;
				KIND_SHADOW, KIND_GLOW, KIND_BEVEL: ph = PH_C0;
				KIND_CONVOLVE: ph = PH_COLS;
				KIND_CMATRIX: begin
					skip_cnt = CMATRIX_LEN;
					ph = PH_SKIP;
				end
				default: ph = PH_GCOUNT;
				endcase
			end
		end
		PH_C0, PH_C1, PH_BX, PH_BY, PH_ANG, PH_DIST, PH_STR: begin
			// colours arrive big-endian, words and strength little-endian
			if (ph == PH_C0 || ph == PH_C1)
				word = {word[23:0], b};
			else
				word = word | ({24'd0, b} << (8 * bpos[1:0]));
			if ({1'b0, bpos} + 4'd1 < ((ph == PH_STR) ? 4'd2 : 4'd4)) begin
				bpos = bpos + 3'd1;
			end else begin
				case (ph)
				PH_C0: begin
					col0 = word;
					ph = (kind == KIND_BEVEL) ? PH_C1 : PH_BX;
				end
				PH_C1: begin
					col1 = word;
					ph = PH_BX;
				end
				PH_BX: begin
					bx = word;
					ph = PH_BY;
				end
				PH_BY: begin
					by = word;
					if (kind == KIND_BLUR)
						ph = PH_FLAGS;
					else if (kind == KIND_GLOW)
						ph = PH_STR;
					else
						ph = PH_ANG;
				end
				PH_ANG: begin
					ang = word;
					ph = PH_DIST;
				end
				PH_DIST: begin
					dist_w = word;
					ph = PH_STR;
				end
				default: begin
					strength = word[15:0];
					ph = PH_FLAGS;
				end
				endcase
				bpos = '0;
				word = '0;
			end
		end
		PH_FLAGS: begin
			// decode passes and mode bits, layout depends on the kind
			mode = '0;
			if (kind == KIND_BLUR) begin
				passes = b[7:3];
			end else begin
				mode[0] = b[7];
				mode[1] = b[6];
				mode[2] = !b[5];
				if (kind == KIND_BEVEL) begin
					mode[3] = b[4];
					passes = {1'b0, b[3:0]};
				end else begin
					passes = b[4:0];
				end
			end
			if (store_en)
				n_added = n_added + 8'd1;
			finish_record({1'b0, kind}, passes, mode);
		end
		PH_GCOUNT: begin
			skip_cnt = GRAD_BASE + 18'd5 * b;
			ph = PH_SKIP;
		end
		PH_COLS: begin
			cols = b;
			ph = PH_ROWS;
		end
		PH_ROWS: begin
			skip_cnt = CONV_BASE + 18'd4 * cols * b;
			ph = PH_SKIP;
		end
		PH_SKIP: begin
			if (skip_cnt != '0)
				skip_cnt = skip_cnt - 18'd1;
			if (skip_cnt == '0) begin
				if (kind == KIND_CMATRIX)
					n_added = n_added + 8'd1 + store_en;
				finish_record({1'b0, kind}, 5'd0, 4'd0);
			end
		end
		default: ph = PH_COUNT;
		endcase
	endtask

	task automatic note_field(input string name, input logic [36:0] want,
			input logic [36:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endtask

	// Compare one result item with the oldest expected record
	task automatic check_record();
		res_t w;
		if (records_due.size() == 0) begin
			$error("result item with nothing expected: filter_kind %0d", filter_kind);
			fails++;
		end else begin
			w = records_due.pop_front();
			note_field("filter_kind", w.filter_kind, filter_kind);
			note_field("first_colour", w.first_colour, first_colour);
			note_field("second_colour", w.second_colour, second_colour);
			note_field("blur_x_twips", w.blur_x_twips, blur_x_twips);
			note_field("blur_y_twips", w.blur_y_twips, blur_y_twips);
			note_field("angle_raw", w.angle_raw, angle_raw);
			note_field("distance_raw", w.distance_raw, distance_raw);
			note_field("strength_raw", w.strength_raw, strength_raw);
			note_field("pass_count", w.pass_count, pass_count);
			note_field("mode_bits", w.mode_bits, mode_bits);
			note_field("added_count", w.added_count, added_count);
			note_field("list_end", w.list_end, list_end);
		end
	endtask

	// Sample both handshakes; predict on accepted bytes, check accepted results
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall)
			check_record();
		if (arst_n && in_valid && !in_stall)
			walk_byte(stream_byte);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > limit_cycles) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int draw_gap();
		int r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Feed bytes from the queue, with random gaps and calm stretches
	int gap_left = 0;
	int feed_calm = 0;
	always @(negedge clk) begin : feed_drive
		feed_t f;
		if (!in_valid || in_taken) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (byte_q.size() != 0) begin
				f = byte_q.pop_front();
				in_valid <= 1'b1;
				stream_byte <= f.data;
				if (f.rush) begin
					gap_left = 0;
				end else if (feed_calm > 0) begin
					feed_calm--;
					gap_left = 0;
				end else begin
					if ($urandom_range(0, 49) == 0)
						feed_calm = $urandom_range(30, 150);
					gap_left = draw_gap();
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side at random, with calm stretches
	int stall_left = 0;
	int drain_calm = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (drain_calm > 0)
				drain_calm--;
			else if ($urandom_range(0, 199) == 0)
				drain_calm = $urandom_range(30, 200);
			else if ($urandom_range(0, 3) == 0)
				stall_left = draw_gap();
		end
	end

	task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
		limit_cycles += 20;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx) << 2;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_STORE_EN)
			store_en = val[0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_check(input logic [0:0] idx, input logic [31:0] want);
		limit_cycles += 20;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'(idx) << 2;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want) begin
			$error("store_enabled readback: expected 0x%0h, got 0x%0h", want, prdata);
			fails++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Queue one byte; body bytes of skipped records do not count as lead bytes
	task automatic put(input logic [7:0] b, input bit body, input bit rush);
		feed_t f;
		f.data = b;
		f.rush = rush;
		byte_q.push_back(f);
		if (!body)
			lead_bytes++;
		limit_cycles += rush ? 2 : 400;
	endtask

	function automatic logic [7:0] fill_byte(input int fill);
		case (fill)
		FILL_ZERO: return 8'h00;
		FILL_ONES: return 8'hFF;
		default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_empty();
		put(8'd0, 1'b0, 1'b0);
		recs_made++;
		limit_cycles += 50;
	endtask

	// Queue one record: type byte, then the body that its kind calls for
	task automatic add_record(input logic [7:0] t, input int fill, input int flg,
			input int sa, input int sb);
		int len;
		int na;
		int nb;
		recs_made++;
		limit_cycles += 50;
		put(t, 1'b0, 1'b0);
		if (t <= TYPE_MAX) begin
			case (t[2:0])
			KIND_SHADOW, KIND_BLUR, KIND_GLOW, KIND_BEVEL: begin
				if (t[2:0] == KIND_SHADOW)
					len = 22;
				else if (t[2:0] == KIND_BLUR)
					len = 8;
				else if (t[2:0] == KIND_GLOW)
					len = 14;
				else
					len = 26;
				repeat (len)
					put(fill_byte(fill), 1'b0, 1'b0);
				put((flg == PICK) ? 8'($urandom) : 8'(flg), 1'b0, 1'b0);
			end
			KIND_CONVOLVE: begin
				na = (sa == PICK) ? $urandom_range(0, 3) : sa;
				nb = (sb == PICK) ? $urandom_range(0, 3) : sb;
				put(8'(na), 1'b0, 1'b0);
				put(8'(nb), 1'b0, 1'b0);
				len = 13 + 4 * na * nb;
				repeat (len)
					put(fill_byte(fill), 1'b1, len > 5000);
			end
			KIND_CMATRIX: begin
				repeat (80)
					put(fill_byte(fill), 1'b1, 1'b0);
			end
			default: begin
				na = (sa == PICK) ? $urandom_range(0, 4) : sa;
				put(8'(na), 1'b0, 1'b0);
				repeat (19 + 5 * na)
					put(fill_byte(fill), 1'b1, 1'b0);
			end
			endcase
		end
	endtask

	function automatic logic [7:0] rand_kind();
		int r = $urandom_range(0, 99);
		if (r < 70)
			return 8'($urandom_range(0, 3));
		if (r < 88)
			return 8'($urandom_range(4, 7));
		return 8'($urandom_range(8, 255));
	endfunction

	// Random well-formed lists with random content; unknown types act as noise
	task automatic rand_lists(input int want_bytes, input int want_recs);
		int cnt;
		lead_bytes = 0;
		recs_made = 0;
		while (lead_bytes < want_bytes || recs_made < want_recs) begin
			if ($urandom_range(0, 9) == 0) begin
				add_empty();
			end else begin
				cnt = $urandom_range(1, 8);
				put(8'(cnt), 1'b0, 1'b0);
				repeat (cnt)
					add_record(rand_kind(), FILL_RAND, PICK, PICK, PICK);
			end
		end
	endtask

	// Wait until every byte is taken and every expected record has come out
	task automatic settle();
		while (byte_q.size() != 0 || in_valid || records_due.size() != 0)
			@(posedge clk);
		repeat (6)
			@(posedge clk);
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		reg_check(REG_STORE_EN, 32'd1);

		// directed: empty list, field extremes, every kind, unknown types
		add_empty();
		put(8'd12, 1'b0, 1'b0);
		add_record({5'd0, KIND_SHADOW}, FILL_ONES, 8'hFF, PICK, PICK);
		add_record({5'd0, KIND_BLUR}, FILL_ZERO, 8'h00, PICK, PICK);
		add_record({5'd0, KIND_BLUR}, FILL_ONES, 8'hFF, PICK, PICK);
		add_record({5'd0, KIND_GLOW}, FILL_RAND, 8'h20, PICK, PICK);
		add_record({5'd0, KIND_BEVEL}, FILL_ONES, 8'h10, PICK, PICK);
		add_record({5'd0, KIND_BEVEL}, FILL_ZERO, 8'hEF, PICK, PICK);
		add_record({5'd0, KIND_GGLOW}, FILL_RAND, PICK, 0, PICK);
		add_record({5'd0, KIND_GBEVEL}, FILL_RAND, PICK, 2, PICK);
		add_record({5'd0, KIND_CONVOLVE}, FILL_RAND, PICK, 0, 7);
		add_record({5'd0, KIND_CONVOLVE}, FILL_RAND, PICK, 2, 3);
		add_record({5'd0, KIND_CMATRIX}, FILL_RAND, PICK, PICK, PICK);
		add_record(8'd8, FILL_RAND, PICK, PICK, PICK);
		// unknown type as the last record: next byte is a new count
		put(8'd2, 1'b0, 1'b0);
		add_record(8'hFF, FILL_RAND, PICK, PICK, PICK);
		add_record(8'h80, FILL_RAND, PICK, PICK, PICK);
		settle();

		// store disabled: only colour matrix records count
		reg_write(REG_STORE_EN, 32'd0);
		reg_check(REG_STORE_EN, 32'd0);
		put(8'd3, 1'b0, 1'b0);
		add_record({5'd0, KIND_SHADOW}, FILL_RAND, PICK, PICK, PICK);
		add_record({5'd0, KIND_CMATRIX}, FILL_RAND, PICK, PICK, PICK);
		add_record({5'd0, KIND_BLUR}, FILL_RAND, PICK, PICK, PICK);
		rand_lists(30, 2);
		settle();

		reg_write(REG_STORE_EN, 32'd1);
		reg_check(REG_STORE_EN, 32'd1);
		rand_lists(55, 4);
		settle();

		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
